// File: design/mgvu_pkg.sv
// types, constants and helpers for the multi-guest virtual uart console
// no dependencies; imported by multi_guest_virtual_uart_console_top
package mgvu_pkg;

    localparam int NUM_GUESTS  = 8;
    localparam int RING_SLOTS  = 8;
    localparam int MAX_RESULTS = 3;

    localparam int GUEST_W    = 3;
    localparam int RING_AW    = $clog2(RING_SLOTS);
    localparam int RING_DEPTH = NUM_GUESTS * RING_SLOTS;
    localparam int RING_ADW   = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(MAX_RESULTS + 1);

    // status and mode bit positions
    localparam int BIT_URXDA   = 0;
    localparam int BIT_TRMT    = 8;
    localparam int BIT_UTXBF   = 9;
    localparam int BIT_UTXEN   = 10;
    localparam int BIT_MODE_ON = 15;

    localparam logic [7:0] CH_ESC        = 8'h05;
    localparam logic [7:0] CH_BELL       = 8'h07;
    localparam logic [7:0] CH_BS         = 8'h08;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0a;
    localparam logic [7:0] CH_CR         = 8'h0d;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_MASK7      = 8'h7f;
    localparam logic [7:0] CH_PRINT_MASK = 8'h60;

    // register offsets
    localparam logic [3:0] REG_MODE    = 4'd0;
    localparam logic [3:0] REG_MODECLR = 4'd1;
    localparam logic [3:0] REG_MODESET = 4'd2;
    localparam logic [3:0] REG_MODEINV = 4'd3;
    localparam logic [3:0] REG_STA     = 4'd4;
    localparam logic [3:0] REG_STACLR  = 4'd5;
    localparam logic [3:0] REG_STASET  = 4'd6;
    localparam logic [3:0] REG_STAINV  = 4'd7;
    localparam logic [3:0] REG_TXREG   = 4'd8;
    localparam logic [3:0] REG_RXREG   = 4'd9;

    // item kinds
    localparam logic [1:0] MODE_HOST_CHAR = 2'd0;
    localparam logic [1:0] MODE_REG_WRITE = 2'd1;
    localparam logic [1:0] MODE_REG_READ  = 2'd2;

    localparam logic IRQ_TX = 1'b0;
    localparam logic IRQ_RX = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXE,
        ST_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic               handled;
        logic               pass_through;
        logic [31:0]        rdata;
        logic               out_char_valid;
        logic [7:0]         out_char;
        logic               irq_valid;
        logic               irq_kind;
        logic [GUEST_W-1:0] irq_guest;
        logic               host_wake;
        logic               last;
    } result_t;

    function automatic logic [RING_AW-1:0] ptr_inc(input logic [RING_AW-1:0] p);
        logic [RING_AW-1:0] r;
        if (p == RING_AW'(RING_SLOTS - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

endpackage

// File: design/multi_guest_virtual_uart_console_top.sv
// multi-guest virtual uart console: register emulation and host character routing
// depends on mgvu_pkg
//
// usage
//   input channel (in_valid / in_stall) carries one item: a host character, a guest
//   register write or a guest register read. output channel (out_valid / out_stall)
//   returns one to three result transfers per item, the final one flagged by last.
//   the user writes guest_present via cfg_we / cfg_wdata only while the block is idle; not enforced.
// timing
//   an item is taken in idle, the state memory and receive ring are read on that edge,
//   the next cycle computes and writes back, then one result per cycle is loaded into
//   the single output register, unless a stalled result is held there.
//   the next item is taken while the last result still waits in the output register.
// reset
//   asynchronous, active low: status and mode registers read zero, ring pointers,
//   target guest and escape flag clear, guest_present becomes 1. ring contents are
//   undefined but never read before written.
// stall
//   a stalled result holds in the output register; further results wait in the
//   result list and in_stall stays high until the last of them is loaded.
module multi_guest_virtual_uart_console_top
    import mgvu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [GUEST_W-1:0] guest,
    input  logic [3:0]         reg_sel,
    input  logic [31:0]        wdata,

    output logic               out_valid,
    input  logic               out_stall,
    output logic               handled,
    output logic               pass_through,
    output logic [31:0]        rdata,
    output logic               out_char_valid,
    output logic [7:0]         out_char,
    output logic               irq_valid,
    output logic               irq_kind,
    output logic [GUEST_W-1:0] irq_guest,
    output logic               host_wake,
    output logic               last
);

    // memories
    logic [63:0] sm_mem   [NUM_GUESTS];
    logic [7:0]  ring_mem [RING_DEPTH];

    // control and state registers
    ctl_state_t          state_reg, state_next;
    logic [7:0]          guest_present_reg;
    logic [GUEST_W-1:0]  rx_target_reg, rx_target_next;
    logic                escape_pending_reg, escape_pending_next;
    logic [RING_AW-1:0]  rptr_reg [NUM_GUESTS];
    logic [RING_AW-1:0]  wptr_reg [NUM_GUESTS];
    logic [NUM_GUESTS-1:0] sm_valid_reg;

    // item and read data
    logic [1:0]          item_mode_reg;
    logic [3:0]          item_sel_reg;
    logic [31:0]         item_wdata_reg;
    logic                item_ok_reg;
    logic [GUEST_W-1:0]  sm_addr_reg;
    logic [63:0]         sm_rdata_reg;
    logic [7:0]          ring_rdata_reg;

    // result list and output register
    result_t             list_reg [MAX_RESULTS];
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    result_t             out_reg;
    logic                out_valid_reg;

    // control
    logic                accept;
    logic                exe_go;
    logic                emit_fire;
    logic                emit_done;

    // accept-side addressing
    logic                in_ok;
    logic [GUEST_W-1:0]  tgt_eff;
    logic [GUEST_W-1:0]  acc_idx;
    logic [RING_ADW-1:0] ring_raddr;

    // execute-side
    logic [31:0]         stat_cur, mode_cur, stat_new, mode_new;
    logic [7:0]          c;
    logic [7:0]          digit;
    logic [RING_AW-1:0]  rp, wp;
    logic                full, nonempty;
    logic [RING_ADW-1:0] ring_waddr;
    logic                sm_we, ring_we, wptr_upd, rptr_upd, wake;
    result_t             list [MAX_RESULTS];
    logic [CNT_W-1:0]    n;
    result_t             blank;

    assign accept = in_valid && !in_stall;

    // ---------------- accept-side addressing ----------------
    always_comb
    begin
        in_ok   = 32'(guest) < NUM_GUESTS;
        tgt_eff = (32'(rx_target_reg) < NUM_GUESTS) ? rx_target_reg : '0;
        if (mode == MODE_HOST_CHAR)
            acc_idx = tgt_eff;
        else if (in_ok)
            acc_idx = guest;
        else
            acc_idx = '0;
        ring_raddr = RING_ADW'(32'(acc_idx) * RING_SLOTS + 32'(rptr_reg[acc_idx]));
    end

    // ---------------- execute ----------------
    always_comb
    begin
        blank      = '0;
        stat_cur   = sm_valid_reg[sm_addr_reg] ? sm_rdata_reg[31:0]  : '0;
        mode_cur   = sm_valid_reg[sm_addr_reg] ? sm_rdata_reg[63:32] : '0;
        c          = item_wdata_reg[7:0];
        digit      = c - CH_ZERO;
        rp         = rptr_reg[sm_addr_reg];
        wp         = wptr_reg[sm_addr_reg];
        full       = ptr_inc(wp) == rp;
        nonempty   = rp != wp;
        ring_waddr = RING_ADW'(32'(sm_addr_reg) * RING_SLOTS + 32'(wp));

        stat_new            = stat_cur;
        mode_new            = mode_cur;
        sm_we               = 1'b0;
        ring_we             = 1'b0;
        wptr_upd            = 1'b0;
        rptr_upd            = 1'b0;
        wake                = 1'b0;
        escape_pending_next = escape_pending_reg;
        rx_target_next      = rx_target_reg;
        n                   = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
            list[i] = '0;

        case (item_mode_reg)
            MODE_HOST_CHAR:
            begin
                if (escape_pending_reg)
                begin
                    escape_pending_next = 1'b0;
                    if (32'(digit) < NUM_GUESTS)
                    begin
                        if (digit < 8'd8 && (digit == 8'd0 || guest_present_reg[digit[2:0]]))
                            rx_target_next = digit[GUEST_W-1:0];
                    end
                    else
                    begin
                        list[n]                = blank;
                        list[n].out_char_valid = 1'b1;
                        list[n].out_char       = CH_BELL;
                        n                      = n + 1'b1;
                    end
                end
                else if ((c & CH_MASK7) == CH_ESC)
                begin
                    escape_pending_next = 1'b1;
                end
                else
                begin
                    if (full)
                    begin
                        list[n].out_char_valid = 1'b1;
                        list[n].out_char       = CH_BELL;
                        n                      = n + 1'b1;
                    end
                    else
                    begin
                        ring_we  = 1'b1;
                        wptr_upd = 1'b1;
                    end
                    stat_new[BIT_URXDA] = 1'b1;
                    sm_we               = 1'b1;
                    if (sm_addr_reg == '0)
                    begin
                        if (c == CH_CR)
                        begin
                            list[n].out_char_valid = 1'b1;
                            list[n].out_char       = CH_LF;
                            n                      = n + 1'b1;
                        end
                        if ((|(c & CH_PRINT_MASK)) || c == CH_CR || c == CH_TAB
                            || c == CH_BELL || c == CH_BS)
                        begin
                            list[n].out_char_valid = 1'b1;
                            list[n].out_char       = c;
                            n                      = n + 1'b1;
                        end
                        wake = 1'b1;
                    end
                    else
                    begin
                        list[n].irq_valid = 1'b1;
                        list[n].irq_kind  = IRQ_RX;
                        list[n].irq_guest = sm_addr_reg;
                        n                 = n + 1'b1;
                    end
                end
            end
            MODE_REG_WRITE:
            begin
                n               = CNT_W'(1);
                list[0].handled = 1'b1;
                if (item_sel_reg == REG_TXREG)
                begin
                    list[0].out_char_valid = 1'b1;
                    list[0].out_char       = item_wdata_reg[7:0];
                end
                if (item_ok_reg)
                begin
                    case (item_sel_reg)
                        REG_MODE:    mode_new = item_wdata_reg;
                        REG_MODECLR: mode_new = mode_cur & ~item_wdata_reg;
                        REG_MODESET: mode_new = mode_cur | item_wdata_reg;
                        REG_MODEINV: mode_new = mode_cur ^ item_wdata_reg;
                        REG_STA:     stat_new = item_wdata_reg;
                        REG_STACLR:  stat_new = stat_cur & ~item_wdata_reg;
                        REG_STASET:  stat_new = stat_cur | item_wdata_reg;
                        REG_STAINV:  stat_new = stat_cur ^ item_wdata_reg;
                        default:     ;
                    endcase
                    sm_we = 1'b1;
                    if (stat_new[BIT_UTXEN] && mode_new[BIT_MODE_ON])
                    begin
                        list[0].irq_valid = 1'b1;
                        list[0].irq_kind  = IRQ_TX;
                        list[0].irq_guest = sm_addr_reg;
                    end
                end
            end
            MODE_REG_READ:
            begin
                n = CNT_W'(1);
                case (item_sel_reg)
                    REG_RXREG:
                    begin
                        list[0].handled = 1'b1;
                        if (item_ok_reg)
                        begin
                            if (nonempty)
                            begin
                                list[0].rdata = {24'd0, ring_rdata_reg};
                                rptr_upd      = 1'b1;
                            end
                            // ring empty once this pop is done
                            if (!nonempty || ptr_inc(rp) == wp)
                            begin
                                stat_new[BIT_URXDA] = 1'b0;
                                sm_we               = 1'b1;
                            end
                        end
                    end
                    REG_STA:
                    begin
                        list[0].handled = 1'b1;
                        if (item_ok_reg)
                        begin
                            list[0].rdata            = stat_cur;
                            list[0].rdata[BIT_UTXBF] = 1'b0;
                            list[0].rdata[BIT_URXDA] = nonempty;
                        end
                        list[0].rdata[BIT_TRMT] = 1'b1;
                    end
                    REG_MODE:
                    begin
                        list[0].handled = 1'b1;
                        list[0].rdata   = item_ok_reg ? mode_cur : '0;
                    end
                    REG_MODECLR, REG_MODESET, REG_MODEINV,
                    REG_STACLR, REG_STASET, REG_STAINV:
                    begin
                        // alias read: nothing returned
                    end
                    default:
                    begin
                        list[0].pass_through = 1'b1;
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        if (n == '0)
            n = CNT_W'(1);
        list[n - 1'b1].last      = 1'b1;
        list[n - 1'b1].host_wake = wake;
    end

    // ---------------- control fsm ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_EXE;
            ST_EXE:  state_next = ST_EMIT;
            ST_EMIT: if (emit_done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        exe_go    = 1'b0;
        emit_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_stall = 1'b0;
            ST_EXE:  exe_go = 1'b1;
            ST_EMIT: emit_fire = !out_valid_reg || !out_stall;
            default: ;
        endcase
        emit_done = emit_fire && (idx_reg == cnt_reg - 1'b1);
        idx_next  = emit_done ? '0 : idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            guest_present_reg  <= 8'd1;
            rx_target_reg      <= '0;
            escape_pending_reg <= 1'b0;
            sm_valid_reg       <= '0;
            idx_reg            <= '0;
            cnt_reg            <= '0;
            out_valid_reg      <= 1'b0;
            for (int i = 0; i < NUM_GUESTS; i++)
            begin
                rptr_reg[i] <= '0;
                wptr_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                guest_present_reg <= cfg_wdata;
            if (exe_go)
            begin
                rx_target_reg      <= rx_target_next;
                escape_pending_reg <= escape_pending_next;
                cnt_reg            <= n;
                if (sm_we)
                    sm_valid_reg[sm_addr_reg] <= 1'b1;
                if (wptr_upd)
                    wptr_reg[sm_addr_reg] <= ptr_inc(wp);
                if (rptr_upd)
                    rptr_reg[sm_addr_reg] <= ptr_inc(rp);
            end
            if (emit_fire)
                idx_reg <= idx_next;
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_mode_reg  <= mode;
            item_sel_reg   <= reg_sel;
            item_wdata_reg <= wdata;
            item_ok_reg    <= in_ok;
            sm_addr_reg    <= acc_idx;
        end
        if (exe_go)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
                list_reg[i] <= list[i];
        end
        if (emit_fire)
            out_reg <= list_reg[idx_reg];
    end

    // state memory: {mode, status} per guest
    always_ff @(posedge clk)
    begin
        if (exe_go && sm_we)
            sm_mem[sm_addr_reg] <= {mode_new, stat_new};
        if (accept)
            sm_rdata_reg <= sm_mem[acc_idx];
    end

    // receive rings
    always_ff @(posedge clk)
    begin
        if (exe_go && ring_we)
            ring_mem[ring_waddr] <= c;
        if (accept)
            ring_rdata_reg <= ring_mem[ring_raddr];
    end

    assign out_valid      = out_valid_reg;
    assign handled        = out_reg.handled;
    assign pass_through   = out_reg.pass_through;
    assign rdata          = out_reg.rdata;
    assign out_char_valid = out_reg.out_char_valid;
    assign out_char       = out_reg.out_char;
    assign irq_valid      = out_reg.irq_valid;
    assign irq_kind       = out_reg.irq_kind;
    assign irq_guest      = out_reg.irq_guest;
    assign host_wake      = out_reg.host_wake;
    assign last           = out_reg.last;

`ifndef NO_ASSERTIONS
    a_accept_to_exe: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_EXE)
        else $error("accepted item did not move to execute");

    a_emit_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> (cnt_reg != '0 && idx_reg < cnt_reg))
        else $error("result index outside the result list");

    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> (list_reg[idx_reg].last == emit_done))
        else $error("last flag not on the final result");

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        (exe_go && ring_we) |-> !full)
        else $error("receive ring written while full");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit_done |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("item not finished after final result");
`endif

endmodule
